/* rtl/bfsp_pkg.sv */
// Shared constants for the shortest-path engine.
`default_nettype none

package bfsp_pkg;

  localparam int VERTICES    = 8;
  localparam int VIDX_W      = $clog2(VERTICES);
  localparam int NUM_ENTRIES = VERTICES * VERTICES;
  localparam int ADDR_W      = 2 * VIDX_W;

  localparam int VTX_W  = 3;
  localparam int WGT_W  = 16;
  localparam int DIST_W = 24;
  localparam int SUM_W  = DIST_W + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

endpackage

`default_nettype wire

/* rtl/bellman_ford_shortest_paths.sv */
// Bellman-Ford shortest-path engine over an adjacency-matrix weight store.
// A load beat writes one weight and leaves the engine ready. A run beat starts
// passes over every edge of the matrix, the last a check pass, each edge read (ST_RD) and then
// relaxed (ST_EX) through one shared add/clamp/compare unit, then one result per
// vertex or a single negative-cycle beat (ST_ERD, ST_EMIT), held by any output stall; the
// check pass ends early on a negative cycle. Reset (async, active low) empties
// the weight store through per-entry valid bits and leaves both channels idle.
`default_nettype none

module bellman_ford_shortest_paths
  import bfsp_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire               in_operation_i,
  input  wire  [VTX_W-1:0]  in_from_vertex_i,
  input  wire  [VTX_W-1:0]  in_to_vertex_i,
  input  wire  [WGT_W-1:0]  in_edge_weight_i,
  input  wire  [VTX_W-1:0]  in_source_vertex_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [VTX_W-1:0]  out_vertex_o,
  output logic [DIST_W-1:0] out_path_length_o,
  output logic              out_reachable_o,
  output logic              out_negative_cycle_o,
  output logic              out_last_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_EX   = 3'd2;
  localparam logic [2:0] ST_ERD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VERTICES - 1);

  logic [2:0]          state_q, state_d;
  logic [VIDX_W-1:0]   u_q, u_d, v_q, v_d, pass_q, pass_d;
  logic                cycle_q, cycle_d;
  logic [VERTICES-1:0] known_q, known_d;
  logic [NUM_ENTRIES-1:0] wvld_q;

  logic [WGT_W-1:0]  wgt_mem [NUM_ENTRIES];
  logic [DIST_W-1:0] dist_mem [VERTICES];
  logic [WGT_W-1:0]  wgt_rd_q;
  logic              wgt_vld_q;
  logic [DIST_W-1:0] dist_a_q, dist_b_q;

  logic              in_acc;
  logic              load_wr;
  logic [ADDR_W-1:0] load_addr;
  logic [ADDR_W-1:0] edge_addr;
  logic              dist_we;
  logic [VIDX_W-1:0] dist_waddr;
  logic [DIST_W-1:0] dist_wdata;

  logic [WGT_W-1:0]  w_eff;
  logic [SUM_W-1:0]  sum;
  logic              sat_hi, sat_lo;
  logic [DIST_W-1:0] cand;
  logic              considered, improve, is_check;
  logic              out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign load_wr   = in_acc && (in_operation_i == OP_LOAD)
                     && (int'(in_from_vertex_i) < VERTICES)
                     && (int'(in_to_vertex_i) < VERTICES);
  assign load_addr = {VIDX_W'(in_from_vertex_i), VIDX_W'(in_to_vertex_i)};
  assign edge_addr = {u_q, v_q};

  // shared relaxation unit: add, clamp to 24 bits, compare against target
  assign w_eff    = wgt_vld_q ? wgt_rd_q : '0;
  assign sum      = {dist_a_q[DIST_W-1], dist_a_q}
                    + {{(SUM_W-WGT_W){w_eff[WGT_W-1]}}, w_eff};
  assign sat_hi   = !sum[SUM_W-1] && sum[SUM_W-2];
  assign sat_lo   = sum[SUM_W-1] && !sum[SUM_W-2];
  assign cand     = sat_hi ? DIST_MAX : (sat_lo ? DIST_MIN : sum[DIST_W-1:0]);
  assign considered = (w_eff != '0) && known_q[u_q];
  assign improve  = considered
                    && (!known_q[v_q] || ($signed(cand) < $signed(dist_b_q)));
  assign is_check = (pass_q == LAST_IDX);

  assign out_load = (state_q == ST_EMIT) && (!out_valid_o || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    u_d        = u_q;
    v_d        = v_q;
    pass_d     = pass_q;
    cycle_d    = cycle_q;
    known_d    = known_q;
    dist_we    = 1'b0;
    dist_waddr = v_q;
    dist_wdata = cand;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_operation_i == OP_RUN)) begin
          u_d     = '0;
          v_d     = '0;
          pass_d  = '0;
          cycle_d = 1'b0;
          known_d = '0;
          if (int'(in_source_vertex_i) < VERTICES) begin
            known_d[VIDX_W'(in_source_vertex_i)] = 1'b1;
            dist_we    = 1'b1;
            dist_waddr = VIDX_W'(in_source_vertex_i);
            dist_wdata = '0;
          end
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_EX;
      end
      ST_EX: begin
        state_d = ST_RD;
        if (is_check) begin
          if (improve) begin
            cycle_d = 1'b1;
            u_d     = '0;
            state_d = ST_ERD;
          end
        end else begin
          if (improve) begin
            dist_we         = 1'b1;
            known_d[v_q]    = 1'b1;
          end
          if (considered && sat_lo) cycle_d = 1'b1;
        end
        if (state_d == ST_RD) begin
          // advance row-major over the matrix, then to the next pass or, after the check pass, to the results
          v_d = v_q + 1'b1;
          if (v_q == LAST_IDX) begin
            v_d = '0;
            u_d = u_q + 1'b1;
            if (u_q == LAST_IDX) begin
              u_d = '0;
              if (is_check) begin
                state_d = ST_ERD;
              end else begin
                pass_d = pass_q + 1'b1;
              end
            end
          end
        end
      end
      ST_ERD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          if (cycle_q || (u_q == LAST_IDX)) begin
            state_d = ST_IDLE;
          end else begin
            u_d     = u_q + 1'b1;
            state_d = ST_ERD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      u_q     <= '0;
      v_q     <= '0;
      pass_q  <= '0;
      cycle_q <= 1'b0;
      known_q <= '0;
      wvld_q  <= '0;
    end else begin
      state_q <= state_d;
      u_q     <= u_d;
      v_q     <= v_d;
      pass_q  <= pass_d;
      cycle_q <= cycle_d;
      known_q <= known_d;
      if (load_wr) wvld_q[load_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) wgt_mem[load_addr] <= in_edge_weight_i;
    wgt_rd_q  <= wgt_mem[edge_addr];
    wgt_vld_q <= wvld_q[edge_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_a_q <= dist_mem[u_q];
    dist_b_q <= dist_mem[v_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (cycle_q) begin
        out_vertex_o         <= '0;
        out_path_length_o    <= '0;
        out_reachable_o      <= 1'b0;
        out_negative_cycle_o <= 1'b1;
        out_last_o           <= 1'b1;
      end else begin
        out_vertex_o         <= VTX_W'(u_q);
        out_path_length_o    <= known_q[u_q] ? dist_a_q : '0;
        out_reachable_o      <= known_q[u_q];
        out_negative_cycle_o <= 1'b0;
        out_last_o           <= (u_q == LAST_IDX);
      end
    end
  end

`ifndef SYNTHESIS
  a_cycle_beat_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_negative_cycle_o |->
      out_last_o && !out_reachable_o && (out_vertex_o == '0))
    else $error("negative-cycle beat malformed");

  a_source_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (known_q != '0))
    else $error("relaxation running with no known vertex");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EX) |-> (pass_q <= LAST_IDX))
    else $error("pass counter out of range");

  a_no_write_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EX) && is_check |-> !dist_we)
    else $error("distance written during check pass");

  a_run_starts_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_operation_i == OP_RUN) |=> (state_q == ST_RD) && !cycle_q)
    else $error("run did not start cleanly");
`endif

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the Bellman-Ford shortest-path engine.
`timescale 1ns / 1ps

module tb
  import bfsp_pkg::*;
();

  localparam int DIST_HI    = 2 ** (DIST_W - 1) - 1;
  localparam int DIST_LO    = -(2 ** (DIST_W - 1));
  localparam int RUN_CYCLES = 2 * VERTICES ** 3 + 2 * VERTICES + 2;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [DIST_W-1:0] path_length;
    logic              reachable;
    logic              negative_cycle;
    logic              last;
  } path_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              in_operation_i;
  logic [VTX_W-1:0]  in_from_vertex_i;
  logic [VTX_W-1:0]  in_to_vertex_i;
  logic [WGT_W-1:0]  in_edge_weight_i;
  logic [VTX_W-1:0]  in_source_vertex_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [VTX_W-1:0]  out_vertex_o;
  logic [DIST_W-1:0] out_path_length_o;
  logic              out_reachable_o;
  logic              out_negative_cycle_o;
  logic              out_last_o;

  // Predictor state: the weight matrix and the per-run distance table.
  int           arc_weight [NUM_ENTRIES];
  int           reach_dist [VERTICES];
  bit           reach_known[VERTICES];
  path_result_t pending_paths[$];

  bit jitter_on;
  int errors_seen;

  bellman_ford_shortest_paths u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_operation_i      (in_operation_i),
    .in_from_vertex_i    (in_from_vertex_i),
    .in_to_vertex_i      (in_to_vertex_i),
    .in_edge_weight_i    (in_edge_weight_i),
    .in_source_vertex_i  (in_source_vertex_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_vertex_o        (out_vertex_o),
    .out_path_length_o   (out_path_length_o),
    .out_reachable_o     (out_reachable_o),
    .out_negative_cycle_o(out_negative_cycle_o),
    .out_last_o          (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // One sweep over every matrix entry in row-major order. With commit set it
  // relaxes and reports a clamp at the low bound; without it it reports
  // whether any entry would still shorten a distance.
  function automatic bit relax_pass(input bit commit);
    bit hit_floor;
    bit low;
    int w;
    int cand;
    hit_floor = 1'b0;
    for (int u = 0; u < VERTICES; u++) begin
      for (int v = 0; v < VERTICES; v++) begin
        w = arc_weight[u * VERTICES + v];
        if (w == 0 || !reach_known[u]) continue;
        cand = reach_dist[u] + w;
        low  = 1'b0;
        if (cand > DIST_HI) cand = DIST_HI;
        if (cand < DIST_LO) begin
          cand = DIST_LO;
          low  = 1'b1;
        end
        if (!reach_known[v] || cand < reach_dist[v]) begin
          if (!commit) return 1'b1;
          reach_dist[v]  = cand;
          reach_known[v] = 1'b1;
          if (low) hit_floor = 1'b1;
        end else if (low && commit) begin
          hit_floor = 1'b1;
        end
      end
    end
    return hit_floor;
  endfunction

  function automatic void solve_paths(input logic [VTX_W-1:0] src);
    bit           cycle;
    path_result_t res;
    int           d;
    for (int i = 0; i < VERTICES; i++) begin
      reach_dist[i]  = 0;
      reach_known[i] = 1'b0;
    end
    if (src < VERTICES) reach_known[src] = 1'b1;
    cycle = 1'b0;
    for (int p = 0; p < VERTICES - 1; p++)
      if (relax_pass(1'b1)) cycle = 1'b1;
    if (relax_pass(1'b0)) cycle = 1'b1;
    if (cycle) begin
      res                = '0;
      res.negative_cycle = 1'b1;
      res.last           = 1'b1;
      pending_paths.push_back(res);
    end else begin
      for (int i = 0; i < VERTICES; i++) begin
        d                  = reach_known[i] ? reach_dist[i] : 0;
        res.vertex         = VTX_W'(i);
        res.path_length    = d[DIST_W-1:0];
        res.reachable      = reach_known[i];
        res.negative_cycle = 1'b0;
        res.last           = (i == VERTICES - 1);
        pending_paths.push_back(res);
      end
    end
  endfunction

  // Drive one input beat and hold it until accepted. Valid stays high after
  // acceptance so back-to-back beats never lower and raise it in one step.
  task automatic send_beat(input logic op, input logic [VTX_W-1:0] from_v,
                           input logic [VTX_W-1:0] to_v, input logic [WGT_W-1:0] wgt,
                           input logic [VTX_W-1:0] src);
    if (jitter_on && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 35);
    end
    in_valid_i         <= 1'b1;
    in_operation_i     <= op;
    in_from_vertex_i   <= from_v;
    in_to_vertex_i     <= to_v;
    in_edge_weight_i   <= wgt;
    in_source_vertex_i <= src;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OP_LOAD) begin
      if (from_v < VERTICES && to_v < VERTICES)
        arc_weight[from_v * VERTICES + to_v] = $signed(wgt);
    end else begin
      solve_paths(src);
    end
  endtask

  // Drop valid so the beat just taken is not taken again, then wait.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_paths.size() != 0);
  endtask

  // Sample results with the values seen at the edge, then pick the next stall.
  always @(posedge clk_i) begin : check_results
    path_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_paths.size() == 0) begin
        $error("unexpected result beat: vertex %0d", out_vertex_o);
        errors_seen++;
      end else begin
        want = pending_paths.pop_front();
        if (out_vertex_o !== want.vertex) begin
          $error("vertex: expected %0d, got %0d", want.vertex, out_vertex_o);
          errors_seen++;
        end
        if (out_path_length_o !== want.path_length) begin
          $error("path_length: expected %0d, got %0d", $signed(want.path_length),
                 $signed(out_path_length_o));
          errors_seen++;
        end
        if (out_reachable_o !== want.reachable) begin
          $error("reachable: expected %0d, got %0d", want.reachable, out_reachable_o);
          errors_seen++;
        end
        if (out_negative_cycle_o !== want.negative_cycle) begin
          $error("negative_cycle: expected %0d, got %0d", want.negative_cycle,
                 out_negative_cycle_o);
          errors_seen++;
        end
        if (out_last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last_o);
          errors_seen++;
        end
      end
    end
    out_stall_i <= jitter_on ? ($urandom_range(99) < 35) : 1'b0;
  end

  task automatic test_directed();
    // Empty store: only the source is reachable.
    send_beat(OP_RUN, 3'd7, 3'd7, 16'hFFFF, 3'd0);
    // Chain through both weight extremes, a zero self-loop and a closing arc.
    send_beat(OP_LOAD, 3'd0, 3'd1, 16'h7FFF, 3'd7);
    send_beat(OP_LOAD, 3'd1, 3'd2, 16'h8000, 3'd0);
    send_beat(OP_LOAD, 3'd2, 3'd7, 16'h0001, 3'd5);
    send_beat(OP_LOAD, 3'd7, 3'd7, 16'h0000, 3'd2);
    send_beat(OP_LOAD, 3'd7, 3'd0, 16'h0005, 3'd7);
    send_beat(OP_RUN, 3'd0, 3'd0, 16'h0000, 3'd0);
    send_beat(OP_RUN, 3'd5, 3'd2, 16'h8000, 3'd7);
    // Arc from a vertex that nothing else reaches.
    send_beat(OP_LOAD, 3'd4, 3'd3, 16'hFFFF, 3'd1);
    send_beat(OP_RUN, 3'd0, 3'd0, 16'h7FFF, 3'd4);
    // Close the chain into a negative loop, then drop the arc again.
    send_beat(OP_LOAD, 3'd7, 3'd0, 16'h8000, 3'd3);
    send_beat(OP_RUN, 3'd1, 3'd6, 16'h1234, 3'd0);
    send_beat(OP_LOAD, 3'd7, 3'd0, 16'h0000, 3'd6);
    send_beat(OP_RUN, 3'd2, 3'd3, 16'h0000, 3'd2);
    // Negative self-loop.
    send_beat(OP_LOAD, 3'd5, 3'd5, 16'hFFFF, 3'd0);
    send_beat(OP_RUN, 3'd0, 3'd7, 16'h0000, 3'd5);
    send_beat(OP_LOAD, 3'd5, 3'd5, 16'h0000, 3'd4);
  endtask

  // Full matrix with no idling on either side.
  task automatic test_dense_graph();
    wait_drained();
    jitter_on = 1'b0;
    for (int r = 0; r < VERTICES; r++)
      for (int c = 0; c < VERTICES; c++)
        send_beat(OP_LOAD, VTX_W'(r), VTX_W'(c), WGT_W'($urandom_range(32767, 1)),
                  VTX_W'($urandom));
    send_beat(OP_RUN, VTX_W'($urandom), VTX_W'($urandom), WGT_W'($urandom), 3'd0);
    send_beat(OP_RUN, VTX_W'($urandom), VTX_W'($urandom), WGT_W'($urandom), 3'd7);
    send_beat(OP_LOAD, 3'd3, 3'd3, 16'h8000, 3'd0);
    send_beat(OP_RUN, VTX_W'($urandom), VTX_W'($urandom), WGT_W'($urandom), 3'd3);
    wait_drained();
    jitter_on = 1'b1;
  endtask

  // Up to four loads followed by a run, with row wipes now and then so that
  // negative loops do not stick around for the rest of the test.
  task automatic test_random_graphs(input int budget);
    int sent;
    int r;
    int w;
    int row;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < budget) begin
      if ($urandom_range(7) == 0) begin
        row = $urandom_range(VERTICES - 1);
        for (int c = 0; c < VERTICES; c++)
          send_beat(OP_LOAD, VTX_W'(row), VTX_W'(c), '0, VTX_W'($urandom));
        sent += VERTICES;
      end
      repeat ($urandom_range(4)) begin
        r = $urandom_range(99);
        if (r < 25)      w = 0;
        else if (r < 75) w = $urandom_range(300, 1);
        else if (r < 90) w = -int'($urandom_range(40, 1));
        else             w = $urandom;
        send_beat(OP_LOAD, VTX_W'($urandom), VTX_W'($urandom), w[WGT_W-1:0],
                  VTX_W'($urandom));
        sent++;
      end
      send_beat(OP_RUN, VTX_W'($urandom), VTX_W'($urandom), WGT_W'($urandom),
                VTX_W'($urandom));
      sent++;
      // Hold off once until every pending result has drained.
      if (!paused && sent >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    in_operation_i     = OP_LOAD;
    in_from_vertex_i   = '0;
    in_to_vertex_i     = '0;
    in_edge_weight_i   = '0;
    in_source_vertex_i = '0;
    out_stall_i        = 1'b0;
    jitter_on          = 1'b1;
    errors_seen        = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_dense_graph();
    test_random_graphs(100);
    wait_drained();
    repeat (RUN_CYCLES) @(posedge clk_i);
    if (errors_seen == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/bfsp_pkg.sv
rtl/bellman_ford_shortest_paths.sv
dv/tb.sv
